// ===== rtl/tmsh_pkg.sv =====
// shared constants and types for the tabulation / multiply-shift hasher
`timescale 1ns / 1ps

package tmsh_pkg;

    localparam int WORD_W        = 64;
    localparam int KEY_BYTES     = WORD_W / 8;
    localparam int TABLE_ENTRIES = 256;
    localparam int ENTRY_AW      = $clog2(TABLE_ENTRIES);
    localparam int SEL_W         = 3;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 3;

    // tdata of the request channel: key, table_select, entry_index, table_word
    localparam int S_FIELDS_W    = WORD_W + SEL_W + ENTRY_AW + WORD_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = WORD_W;

    // low half sum of the multiply-shift: p00 + (p01 + p10) << 32 + addend_low
    localparam int LO_SUM_W      = WORD_W + 34;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [ENTRY_AW-1:0] entry_t;
    typedef logic [SEL_W-1:0]    sel_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef word_t [KEY_BYTES-1:0] bank_words_t;

    // hash kinds
    localparam kind_t KIND_IDENTITY   = 2'd0;
    localparam kind_t KIND_TABULATION = 2'd1;
    localparam kind_t KIND_MUL_SHIFT  = 2'd2;

    // request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_HASH = 1'b1;

    // register indexes
    localparam cfg_idx_t REG_HASH_KIND  = 3'd0;
    localparam cfg_idx_t REG_MULT_LOW   = 3'd1;
    localparam cfg_idx_t REG_MULT_HIGH  = 3'd2;
    localparam cfg_idx_t REG_ADDEND_LOW = 3'd3;
    localparam cfg_idx_t REG_ADDEND_HIGH = 3'd4;

endpackage

// ===== rtl/tabulation_multiply_shift_hasher.sv =====
// top level of the tabulation / multiply-shift key hasher
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tdata (key, table_select, entry_index,
//                                          table_word), s_tuser (mode)
// m_        out  m_tvalid / m_tready       m_tdata (hash_value)
// cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// four register stages: table read and key capture, partial products and pair xor,
// grouped sums and final xor, kind select into the output register
// one request per cycle while the pipeline advances; a hash moves stage by stage
// to the output; a load writes its table entry on acceptance and gives no result
// the whole pipeline advances only while the output register is empty or being
// taken, so a stall freezes every stage and nothing is dropped or repeated
// reset (aresetn low, synchronous) clears the valid bits and the configuration
// registers; table contents are undefined until loaded

module tabulation_multiply_shift_hasher #(
    parameter int BYTE_TABLES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] key, [66:64] table_select, [74:67] entry_index,
    // [138:75] table_word, [143:139] zero
    input  logic [tmsh_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic [0:0]                      s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] hash_value
    output logic [tmsh_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  tmsh_pkg::cfg_idx_t              cfg_index,
    input  tmsh_pkg::word_t                 cfg_data
);
    import tmsh_pkg::*;

    // request fields
    word_t  s_key;
    sel_t   s_table_select;
    entry_t s_entry_index;
    word_t  s_table_word;
    logic   s_mode;

    assign s_key          = s_tdata[WORD_W-1:0];
    assign s_table_select = s_tdata[WORD_W+SEL_W-1:WORD_W];
    assign s_entry_index  = s_tdata[WORD_W+SEL_W+ENTRY_AW-1:WORD_W+SEL_W];
    assign s_table_word   = s_tdata[S_FIELDS_W-1:WORD_W+SEL_W+ENTRY_AW];
    assign s_mode         = s_tuser[0];

    // pipeline control
    logic advance;
    logic s_accept;
    logic hash_accept;
    logic load_accept;

    assign advance     = !m_tvalid || m_tready;
    assign s_tready    = advance;
    assign s_accept    = s_tvalid && s_tready;
    assign hash_accept = s_accept && (s_mode == MODE_HASH);
    assign load_accept = s_accept && (s_mode == MODE_LOAD);

    // configuration registers
    kind_t hash_kind_reg;
    word_t mult_low_reg;
    word_t mult_high_reg;
    word_t addend_low_reg;
    word_t addend_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_kind_reg   <= KIND_IDENTITY;
            mult_low_reg    <= '0;
            mult_high_reg   <= '0;
            addend_low_reg  <= '0;
            addend_high_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HASH_KIND:   hash_kind_reg   <= cfg_data[KIND_W-1:0];
                REG_MULT_LOW:    mult_low_reg    <= cfg_data;
                REG_MULT_HIGH:   mult_high_reg   <= cfg_data;
                REG_ADDEND_LOW:  addend_low_reg  <= cfg_data;
                REG_ADDEND_HIGH: addend_high_reg <= cfg_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // table banks, one per key byte; absent banks read as zero
    bank_words_t bank_rd;

    for (genvar t = 0; t < KEY_BYTES; t++) begin : g_bank
        if (t < BYTE_TABLES) begin : g_present
            logic bank_wr;
            assign bank_wr = load_accept && (s_table_select == SEL_W'(t));

            tmsh_table_bank u_bank (
                .aclk    (aclk),
                .wr_en   (bank_wr),
                .wr_addr (s_entry_index),
                .wr_data (s_table_word),
                .rd_en   (advance),
                .rd_addr (s_key[8*t +: 8]),
                .rd_data (bank_rd[t])
            );
        end else begin : g_absent
            assign bank_rd[t] = '0;
        end
    end

    // key, kind and valid travel beside the datapath
    logic  v1_reg, v2_reg, v3_reg;
    word_t key1_reg, key2_reg, key3_reg;
    kind_t kind1_reg, kind2_reg, kind3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= hash_accept;  // loads leave no trace in the pipeline
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key1_reg  <= s_key;
            kind1_reg <= hash_kind_reg;
            key2_reg  <= key1_reg;
            kind2_reg <= kind1_reg;
            key3_reg  <= key2_reg;
            kind3_reg <= kind2_reg;
        end
    end

    // tabulation xor over the registered bank words
    word_t tab_value;

    tmsh_xor_tree u_xor (
        .aclk      (aclk),
        .en        (advance),
        .words     (bank_rd),
        .tab_value (tab_value)
    );

    // multiply-shift, fed from the stage one key
    word_t       ms_hi_sum;
    logic [33:0] ms_lo_carry;

    tmsh_mul_shift u_mul (
        .aclk        (aclk),
        .en          (advance),
        .key         (key1_reg),
        .mult_low    (mult_low_reg),
        .mult_high   (mult_high_reg),
        .addend_low  (addend_low_reg),
        .addend_high (addend_high_reg),
        .hi_sum      (ms_hi_sum),
        .lo_carry    (ms_lo_carry)
    );

    // output register: kind select, final carry add for multiply-shift
    logic  out_valid_reg;
    logic  out_valid_next;
    word_t out_hash_reg;
    word_t out_hash_next;

    always_comb begin
        unique case (kind3_reg)
            KIND_TABULATION: out_hash_next = tab_value;
            KIND_MUL_SHIFT:  out_hash_next = ms_hi_sum + {30'd0, ms_lo_carry};
            default:         out_hash_next = key3_reg;  // identity, also unused kind
        endcase
    end

    assign out_valid_next = advance ? v3_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_hash_reg <= out_hash_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

`ifndef SYNTHESIS
    // a load never starts a result
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == MODE_LOAD)) |=> !v1_reg)
        else $error("load request entered the hash pipeline");

    // a hash request reaches stage one on the next edge
    a_hash_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == MODE_HASH)) |=> v1_reg)
        else $error("accepted hash lost at pipeline entry");

    // the last stage holding a hash moves into the output register when the pipeline advances
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && advance) |=> m_tvalid)
        else $error("hash lost between last stage and output register");

    // nothing is offered straight after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ===== rtl/tmsh_table_bank.sv =====
// one byte-position tabulation table: 256 x 64 memory with registered read
`timescale 1ns / 1ps

module tmsh_table_bank (
    input  logic            aclk,
    input  logic            wr_en,
    input  tmsh_pkg::entry_t wr_addr,
    input  tmsh_pkg::word_t  wr_data,
    input  logic            rd_en,
    input  tmsh_pkg::entry_t rd_addr,
    output tmsh_pkg::word_t  rd_data
);
    import tmsh_pkg::*;

    word_t mem_reg [TABLE_ENTRIES];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tmsh_xor_tree.sv =====
// two-stage registered xor tree over the table bank read words
`timescale 1ns / 1ps

module tmsh_xor_tree (
    input  logic                  aclk,
    input  logic                  en,
    input  tmsh_pkg::bank_words_t words,
    output tmsh_pkg::word_t       tab_value
);
    import tmsh_pkg::*;

    localparam int PAIRS = KEY_BYTES / 2;

    word_t [PAIRS-1:0] pair_reg;
    word_t [PAIRS-1:0] pair_next;
    word_t             tab_reg;
    word_t             tab_next;

    always_comb begin
        for (int i = 0; i < PAIRS; i++) begin
            pair_next[i] = words[2*i] ^ words[2*i+1];
        end
    end

    always_comb begin
        tab_next = '0;
        for (int i = 0; i < PAIRS; i++) begin
            tab_next = tab_next ^ pair_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pair_reg <= pair_next;
            tab_reg  <= tab_next;
        end
    end

    assign tab_value = tab_reg;

endmodule

// ===== rtl/tmsh_mul_shift.sv =====
// multiply-shift datapath: 32x32 partial products, then grouped sums
`timescale 1ns / 1ps

module tmsh_mul_shift (
    input  logic                  aclk,
    input  logic                  en,
    input  tmsh_pkg::word_t       key,
    input  tmsh_pkg::word_t       mult_low,
    input  tmsh_pkg::word_t       mult_high,
    input  tmsh_pkg::word_t       addend_low,
    input  tmsh_pkg::word_t       addend_high,
    output tmsh_pkg::word_t       hi_sum,
    output logic [33:0]           lo_carry
);
    import tmsh_pkg::*;

    // stage 2: partial products
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg, q00_reg;
    logic [31:0] q01_reg, q10_reg;
    logic [63:0] p00_next, p01_next, p10_next, p11_next, q00_next;
    logic [63:0] q01_full, q10_full;

    // stage 3: sums
    word_t               hi_sum_reg;
    word_t               hi_sum_next;
    logic [LO_SUM_W-1:0] lo_sum_reg;
    logic [LO_SUM_W-1:0] lo_sum_next;
    logic [31:0]         q_mid;

    assign p00_next = {32'd0, mult_low[31:0]}   * {32'd0, key[31:0]};
    assign p01_next = {32'd0, mult_low[31:0]}   * {32'd0, key[63:32]};
    assign p10_next = {32'd0, mult_low[63:32]}  * {32'd0, key[31:0]};
    assign p11_next = {32'd0, mult_low[63:32]}  * {32'd0, key[63:32]};
    assign q00_next = {32'd0, mult_high[31:0]}  * {32'd0, key[31:0]};
    // only the low half of the cross terms survives modulo 2^128
    assign q01_full = {32'd0, mult_high[31:0]}  * {32'd0, key[63:32]};
    assign q10_full = {32'd0, mult_high[63:32]} * {32'd0, key[31:0]};

    assign q_mid = q01_reg + q10_reg;

    assign lo_sum_next = {34'd0, p00_reg}
                       + {2'd0, p01_reg, 32'd0}
                       + {2'd0, p10_reg, 32'd0}
                       + {34'd0, addend_low};

    assign hi_sum_next = p11_reg + q00_reg + {q_mid, 32'd0} + addend_high;

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg    <= p00_next;
            p01_reg    <= p01_next;
            p10_reg    <= p10_next;
            p11_reg    <= p11_next;
            q00_reg    <= q00_next;
            q01_reg    <= q01_full[31:0];
            q10_reg    <= q10_full[31:0];
            hi_sum_reg <= hi_sum_next;
            lo_sum_reg <= lo_sum_next;
        end
    end

    assign hi_sum   = hi_sum_reg;
    assign lo_carry = lo_sum_reg[LO_SUM_W-1:WORD_W];

endmodule
